// ----- hdl/glmd_pkg.sv -----
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared constants and types of the grid local minimum detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glmd_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 1024;

  // line store address and counter widths
  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROWC_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // field widths
  localparam int HGT_W  = 4;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 6;
  localparam int RISK_W = 20;
  localparam int FW_W   = 7;
  localparam int FH_W   = 11;
  localparam int CFG_W  = 11;
  localparam int ENT_W  = 2 * HGT_W;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(64);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);

  localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

  typedef struct packed {
    logic              flush;
    logic              store_only;
    logic              has_up;
    logic              has_left;
    logic              has_right;
    logic              done;
    logic [ADDR_W-1:0] col;
    logic [ROWC_W-1:0] row;
    logic [HGT_W-1:0]  down;
  } glmd_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ENT_W-1:0]  data;
  } glmd_wr_t;

endpackage

`default_nettype wire

// ----- hdl/grid_local_minimum_detector.sv -----
// ----------------------------------------------------------------------------
// grid_local_minimum_detector
// 4-neighbor low point detector over a raster height grid with line buffers.
// Throughput: one item per cycle unless a held result stalls the input; the line
//   store reads two columns per item and writes one back, with write-first bypass on a same-column overlap.
// Path: an accepted item sits in the decision stage register, then its result in the output register.
// Reset: synchronous; counters, phase and risk sum cleared, registers set to
//   64 columns by 1024 rows; line buffer contents stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_local_minimum_detector
  import glmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // height[3:0]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // row[9:0], col[15:10], cell_height[19:16], is_low[20], risk_total[40:21]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // frame_done
  output logic                       m_tlast
);

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [ADDR_W-1:0] col_count;
  logic [ROWC_W-1:0] row_count;
  logic              flushing;

  logic [ADDR_W-1:0] width_m1;
  logic [ROWC_W-1:0] height_m1;
  logic [ADDR_W-1:0] c;
  logic              last_col;
  logic              s_accept;
  logic              take;
  logic              load;
  glmd_item_t        item;
  glmd_wr_t          wr;
  logic [ENT_W-1:0]  rdata_a;
  logic [HGT_W-1:0]  rdata_b;

  always_comb begin
    if (frame_width == '0) begin
      width_m1 = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      width_m1 = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = ADDR_W'(frame_width - FW_W'(1));
    end
    if (frame_height == '0) begin
      height_m1 = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      height_m1 = ROWC_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = ROWC_W'(frame_height - FH_W'(1));
    end
  end

  assign c        = (col_count > width_m1) ? width_m1 : col_count;
  assign last_col = (c == width_m1);
  assign s_accept = s_tvalid && s_tready;
  assign take     = flushing ? s_tuser : !s_tuser;
  assign load     = s_accept && take;

  always_comb begin
    item.flush      = flushing;
    item.store_only = !flushing && (row_count == '0);
    item.has_up     = flushing ? (row_count != '0) : (row_count > ROWC_W'(1));
    item.has_left   = (c != '0);
    item.has_right  = !last_col;
    item.done       = flushing && last_col;
    item.col        = c;
    item.row        = flushing ? row_count : (row_count - ROWC_W'(1));
    item.down       = s_tdata[HGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      col_count    <= '0;
      row_count    <= '0;
      flushing     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        default:          frame_height <= cfg_wdata;
      endcase
      col_count <= '0;
      row_count <= '0;
      flushing  <= 1'b0;
    end else if (load) begin
      if (!last_col) begin
        col_count <= c + ADDR_W'(1);
      end else begin
        col_count <= '0;
        if (flushing) begin
          row_count <= '0;
          flushing  <= 1'b0;
        end else if (row_count >= height_m1) begin
          flushing <= 1'b1;
        end else begin
          row_count <= row_count + ROWC_W'(1);
        end
      end
    end
  end

  glmd_line_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (load),
    .raddr_a (c),
    .raddr_b (c + ADDR_W'(1)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  glmd_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .item     (item),
    .clear    (cfg_we),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .wr       (wr),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // an ignored item must not touch the line store
  a_ignored_no_write: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !take) |=> !wr.we)
    else $error("ignored item wrote the line store");

  // the last flush item restarts the frame
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (load && flushing && last_col) |=> (col_count == '0 && row_count == '0 && !flushing))
    else $error("frame did not restart after its last item");

endmodule

`default_nettype wire

// ----- hdl/glmd_line_store.sv -----
// ----------------------------------------------------------------------------
// glmd_line_store
// Two line buffers in one memory, entry = {older row, previous row}.
// One write port, two registered read ports, write-first on a same-edge hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glmd_line_store
  import glmd_pkg::*;
(
  input  wire logic              clk,
  input  wire glmd_wr_t          wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [ENT_W-1:0]  rdata_a,
  output logic      [HGT_W-1:0]  rdata_b
);

  logic [ENT_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && (wr.addr == raddr_a)) begin
        rdata_a <= wr.data;
      end else begin
        rdata_a <= mem[raddr_a];
      end
      if (wr.we && (wr.addr == raddr_b)) begin
        rdata_b <= wr.data[HGT_W-1:0];
      end else begin
        rdata_b <= mem[raddr_b][HGT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/glmd_decide.sv -----
// ----------------------------------------------------------------------------
// glmd_decide
// Decision stage: neighbor compare, risk sum, line store write-back and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glmd_decide
  import glmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire glmd_item_t            item,
  input  wire logic                  clear,
  input  wire logic [ENT_W-1:0]      rdata_a,
  input  wire logic [HGT_W-1:0]      rdata_b,
  output glmd_wr_t                   wr,
  output logic                       ready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // row[9:0], col[15:10], cell_height[19:16], is_low[20], risk_total[40:21]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // frame_done
  output logic                       m_tlast
);

  logic               s1_valid;
  glmd_item_t         s1;
  logic [HGT_W-1:0]   left_height;
  logic [RISK_W-1:0]  risk;

  logic               out_free;
  logic               advance;
  logic [HGT_W-1:0]   h;
  logic [HGT_W-1:0]   older_cur;
  logic               low;
  logic [RISK_W:0]    risk_sum;
  logic [RISK_W-1:0]  risk_next;

  assign out_free  = !m_tvalid || m_tready;
  assign advance   = s1_valid && out_free;
  assign ready     = !s1_valid || out_free;

  assign h         = rdata_a[HGT_W-1:0];
  assign older_cur = rdata_a[ENT_W-1:HGT_W];

  always_comb begin
    low = 1'b1;
    if (s1.has_left && (left_height <= h)) low = 1'b0;
    if (s1.has_up && (older_cur <= h)) low = 1'b0;
    if (s1.has_right && (rdata_b <= h)) low = 1'b0;
    if (!s1.flush && (s1.down <= h)) low = 1'b0;
  end

  always_comb begin
    risk_sum  = {1'b0, risk} + (RISK_W+1)'(h) + (RISK_W+1)'(1);
    risk_next = risk;
    if (low) begin
      risk_next = risk_sum[RISK_W] ? RISK_MAX : risk_sum[RISK_W-1:0];
    end
  end

  always_comb begin
    wr.we   = advance;
    wr.addr = s1.col;
    wr.data = {h, (s1.flush ? h : s1.down)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      risk     <= '0;
    end else begin
      if (advance && !s1.store_only) begin
        m_tvalid <= 1'b1;
        risk     <= s1.done ? '0 : risk_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (clear) begin
        risk <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !s1.store_only) begin
      left_height <= h;
      m_tdata     <= {7'b0, risk_next, low, h, COL_W'(s1.col), ROW_W'(s1.row)};
      m_tlast     <= s1.done;
    end
  end

endmodule

`default_nettype wire

// ----- dv/grid_local_minimum_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_minimum_detector_tb
// Streams height grids of many sizes through the detector, cell items row by
// row and then flush items. An in-bench predictor with its own line buffers
// works out each cell decision and the running risk sum. Every result is
// compared field by field with the oldest pending decision, while both stream
// sides stall at random.
// ----------------------------------------------------------------------------

module grid_local_minimum_detector_tb;
  import glmd_pkg::*;

  typedef enum logic {
    ACT_CELL  = 1'b0,
    ACT_FLUSH = 1'b1
  } grid_action_t;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [HGT_W-1:0]  height;
    logic              is_low;
    logic [RISK_W-1:0] risk_total;
    logic              frame_done;
  } cell_decision_t;

  // m_tdata layout
  localparam int COL_LSB  = ROW_W;
  localparam int HGT_LSB  = COL_LSB + COL_W;
  localparam int LOW_BIT  = HGT_LSB + HGT_W;
  localparam int RISK_LSB = LOW_BIT + 1;
  localparam int PAD_LSB  = RISK_LSB + RISK_W;
  localparam int PAD_W    = OUT_DATA_W - PAD_LSB;

  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 200;

  // 3x3 grid: low points in two corners, ties, heights above 9
  localparam logic [HGT_W-1:0] DIRECTED_GRID [9] = '{
    4'd0,  4'd5,  4'd9,
    4'd12, 4'd15, 4'd3,
    4'd10, 4'd11, 4'd3
  };

  class low_point_scoreboard;
    logic [HGT_W-1:0] upper_row [MAX_WIDTH];
    logic [HGT_W-1:0] lagging_row [MAX_WIDTH];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      risk_sum;
    int unsigned      width_reg;
    int unsigned      height_reg;
    bit               draining;
    cell_decision_t   decided_cells[$];
    int unsigned      checked;
    int unsigned      low_points;
    int unsigned      frames;
    int unsigned      mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lagging_row[i] = '0;
      end
      width_reg = MAX_WIDTH;
      height_reg = MAX_HEIGHT;
      checked = 0;
      low_points = 0;
      frames = 0;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_pos = 0;
      row_pos = 0;
      risk_sum = 0;
      draining = 1'b0;
    endfunction

    function int pending();
      return decided_cells.size();
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
      else height_reg = val[FH_W-1:0];
      restart_frame();
    endfunction

    function int unsigned active_width();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // decide the cell held in upper_row[c] and shift the column down
    function void decide(int unsigned r, int unsigned c, int unsigned w, bit has_down,
                         logic [HGT_W-1:0] down, bit done);
      cell_decision_t d;
      logic [HGT_W-1:0] h;
      bit low;
      h = upper_row[c];
      low = 1'b1;
      if (c > 0 && lagging_row[c-1] <= h) low = 1'b0;
      if (r > 0 && lagging_row[c] <= h) low = 1'b0;
      if (c + 1 < w && upper_row[c+1] <= h) low = 1'b0;
      if (has_down && down <= h) low = 1'b0;
      if (low) begin
        risk_sum += h + 1;
        if (risk_sum > RISK_MAX) risk_sum = RISK_MAX;
      end
      d.row = r[ROW_W-1:0];
      d.col = c[COL_W-1:0];
      d.height = h;
      d.is_low = low;
      d.risk_total = risk_sum[RISK_W-1:0];
      d.frame_done = done;
      decided_cells = {decided_cells, d};
      lagging_row[c] = h;
    endfunction

    function void advance_grid(logic act, logic [HGT_W-1:0] hgt);
      int unsigned w;
      int unsigned hg;
      int unsigned c;
      int unsigned r;
      w = active_width();
      hg = active_height();
      c = col_pos;
      r = row_pos;
      if (c >= w) c = w - 1;
      if (!draining) begin
        if (act != ACT_CELL) return;
        if (r > 0) decide(r - 1, c, w, 1'b1, hgt, 1'b0);
        else lagging_row[c] = upper_row[c];
        upper_row[c] = hgt;
        if (c + 1 < w) begin
          col_pos = c + 1;
        end else begin
          col_pos = 0;
          if (r + 1 >= hg) draining = 1'b1;
          else row_pos = r + 1;
        end
      end else if (act == ACT_FLUSH) begin
        decide(r, c, w, 1'b0, '0, c + 1 >= w);
        if (c + 1 < w) col_pos = c + 1;
        else restart_frame();
      end
    endfunction

    function void check_decision(logic [OUT_DATA_W-1:0] data, logic last);
      cell_decision_t want;
      cell_decision_t got;
      got.row = data[ROW_W-1:0];
      got.col = data[COL_LSB +: COL_W];
      got.height = data[HGT_LSB +: HGT_W];
      got.is_low = data[LOW_BIT];
      got.risk_total = data[RISK_LSB +: RISK_W];
      got.frame_done = last;
      if (decided_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no decision pending, data %h last %b",
                   $time, data, last);
        return;
      end
      want = decided_cells.pop_front();
      checked++;
      if (want.is_low) low_points++;
      if (want.frame_done) frames++;
      if (got.row !== want.row || got.col !== want.col || got.height !== want.height ||
          got.is_low !== want.is_low || got.risk_total !== want.risk_total ||
          got.frame_done !== want.frame_done || data[PAD_LSB +: PAD_W] !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected row %0d col %0d h %0d low %b risk %0d done %b", $time,
                   want.row, want.col, want.height, want.is_low, want.risk_total,
                   want.frame_done);
          $display("%0t:   actual row %0d col %0d h %0d low %b risk %0d done %b pad %h",
                   $time, got.row, got.col, got.height, got.is_low, got.risk_total,
                   got.frame_done, data[PAD_LSB +: PAD_W]);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  low_point_scoreboard board;
  bit src_idle;
  bit sink_idle;
  bit hold_request;

  grid_local_minimum_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) board.set_register(cfg_addr, cfg_wdata);
      if (s_tvalid && s_tready) board.advance_grid(s_tuser, s_tdata[HGT_W-1:0]);
      if (m_tvalid && m_tready) board.check_decision(m_tdata, m_tlast);
    end
  end

  // result side
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = sink_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && !hold_request) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [HGT_W-1:0] pick_height();
    if ($urandom_range(0, 3) == 0) return HGT_W'($urandom_range(0, 15));
    return HGT_W'($urandom_range(0, 9));
  endfunction

  task automatic send_item(grid_action_t act, logic [HGT_W-1:0] hgt);
    int gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {{(IN_DATA_W - HGT_W){1'b0}}, hgt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_frame_size(logic [CFG_W-1:0] wval, logic [CFG_W-1:0] hval,
                                 bit height_first);
    cfg_we <= 1'b1;
    cfg_addr <= height_first ? CFG_FRAME_HEIGHT : CFG_FRAME_WIDTH;
    cfg_wdata <= height_first ? hval : wval;
    @(posedge clk);
    cfg_addr <= height_first ? CFG_FRAME_WIDTH : CFG_FRAME_HEIGHT;
    cfg_wdata <= height_first ? wval : hval;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one grid in raster order then its flush items, with stray ignored items; a broken grid stops early without flush
  task automatic drive_frame(int w, int h, bit broken, int pause_at, int hold_at,
                             output int sent);
    int n_cells;
    int cut;
    n_cells = w * h;
    cut = broken ? $urandom_range(0, n_cells - 1) : n_cells;
    sent = 0;
    for (int i = 0; i < cut; i++) begin
      if (i == pause_at) settle_results();
      if (i == hold_at) hold_request = 1'b1;
      if ($urandom_range(0, 15) == 0) send_item(ACT_FLUSH, pick_height());
      send_item(ACT_CELL, pick_height());
      sent++;
    end
    if (broken) return;
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(ACT_CELL, pick_height());
      send_item(ACT_FLUSH, pick_height());
      sent++;
    end
  endtask

  initial begin
    int unsigned random_items;
    int sent;
    int w_eff;
    int h_eff;
    int phase;
    int n_frames;
    logic [FW_W-1:0] wsel;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] hval;

    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_CELL;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first row at reset size gives no results
    for (int i = 0; i < 4; i++) send_item(ACT_CELL, HGT_W'(i * 5));
    settle_results();

    // 3x3 grid with a stray item in each phase
    load_frame_size(11'd3, 11'd3, 1'b0);
    send_item(ACT_FLUSH, 4'd15);
    foreach (DIRECTED_GRID[i]) send_item(ACT_CELL, DIRECTED_GRID[i]);
    send_item(ACT_CELL, 4'd0);
    for (int i = 0; i < 3; i++) send_item(ACT_FLUSH, 4'd0);
    settle_results();

    // zero sizes clamp to a single cell, upper width bits ignored
    load_frame_size(11'h780, 11'd0, 1'b1);
    send_item(ACT_CELL, 4'd15);
    send_item(ACT_FLUSH, 4'd9);
    send_item(ACT_CELL, 4'd0);
    send_item(ACT_FLUSH, 4'd0);
    settle_results();

    // full width, long receiver hold once the second row decides
    load_frame_size(11'd64, 11'd2, 1'b0);
    drive_frame(64, 2, 1'b0, -1, 80, sent);
    settle_results();

    // oversized width clamps to full width
    load_frame_size(11'd127, 11'd1, 1'b1);
    drive_frame(64, 1, 1'b0, -1, -1, sent);
    settle_results();

    // one column at full height, no idling
    src_idle = 1'b0;
    sink_idle = 1'b0;
    load_frame_size(11'd1, 11'd2047, 1'b0);
    drive_frame(1, MAX_HEIGHT, 1'b0, -1, -1, sent);
    settle_results();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 15))
        0: wsel = '0;
        1, 2: wsel = FW_W'($urandom_range(9, 127));
        default: wsel = FW_W'($urandom_range(1, 8));
      endcase
      w_eff = (wsel < 1) ? 1 : (wsel > MAX_WIDTH) ? MAX_WIDTH : int'(wsel);
      if (w_eff > 8) hval = CFG_W'($urandom_range(0, 3));
      else if ($urandom_range(0, 7) == 0) hval = CFG_W'($urandom_range(7, 20));
      else hval = CFG_W'($urandom_range(0, 6));
      h_eff = (hval < 1) ? 1 : int'(hval);
      wval = {4'($urandom_range(0, 15) * $urandom_range(0, 1)), wsel};
      load_frame_size(wval, hval, $urandom_range(0, 1));
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        drive_frame(w_eff, h_eff, (f == n_frames - 1) && ($urandom_range(0, 5) == 0),
                    (phase == 2 && f == 0) ? (w_eff * h_eff) / 2 : -1, -1, sent);
        random_items += sent;
      end
      settle_results();
      phase++;
    end

    $display("ran %0d grids with %0d decisions checked, %0d of them low points",
             board.frames, board.checked, board.low_points);
    $display("sizes from a single cell to 64 columns and 1024 rows, both sides stalling");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d decisions never seen", board.mismatches,
               board.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
